>>> src/sqvb_pkg.sv
// shared types, codes and the quarter-wave sine table of the quad vertex batcher
package sqvb_pkg;

    typedef logic [15:0] tex_id_t;
    typedef logic [16:0] sine_mag_t;

    localparam logic        OP_DRAW     = 1'b0;
    localparam logic        OP_BEGIN    = 1'b1;
    localparam logic [13:0] LIMIT_RESET = 14'd10000;
    localparam logic [15:0] TILING_ONE  = 16'h0100;
    localparam logic [31:0] WHITE       = 32'hFFFF_FFFF;

    function automatic sine_mag_t sine_entry(input logic [4:0] idx);
        sine_mag_t v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6424;
            5'd2:    v = 17'd12785;
            5'd3:    v = 17'd19024;
            5'd4:    v = 17'd25080;
            5'd5:    v = 17'd30893;
            5'd6:    v = 17'd36410;
            5'd7:    v = 17'd41576;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd50660;
            5'd10:   v = 17'd54491;
            5'd11:   v = 17'd57798;
            5'd12:   v = 17'd60547;
            5'd13:   v = 17'd62714;
            5'd14:   v = 17'd64277;
            5'd15:   v = 17'd65220;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

>>> src/sqvb_slot_cell.sv
// one texture slot cell: stored texture id and its match against the query
module sqvb_slot_cell #(
    parameter int CellIdx = 1,
    parameter int SuW     = 6
) (
    input  logic              clk,
    input  sqvb_pkg::tex_id_t query,
    input  logic [SuW-1:0]    slots,
    input  logic              wr_en,
    output logic              match
);
    import sqvb_pkg::*;

    tex_id_t id_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_reg <= query;
        end
    end

    assign match = (SuW'(CellIdx) < slots) && (id_reg == query);

endmodule

>>> src/sqvb_sine.sv
// registered sine and cosine of a 16-bit angle by interpolated quarter-wave table
module sqvb_sine (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [17:0] sin_q,
    output logic signed [17:0] cos_q
);
    import sqvb_pkg::*;

    logic signed [17:0] sin_reg;
    logic signed [17:0] cos_reg;

    function automatic logic signed [17:0] sine16(input logic [15:0] a);
        logic [14:0]        p;
        logic [4:0]         i;
        logic [9:0]         f;
        sine_mag_t          t0;
        sine_mag_t          t1;
        logic [12:0]        d;
        logic [22:0]        prod;
        sine_mag_t          mag;
        logic signed [17:0] sval;
        p = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        i = {1'b0, p[13:10]};
        f = p[9:0];
        t0 = sine_entry(i);
        t1 = sine_entry(i + 5'd1);
        d = 13'(t1 - t0);
        prod = ({10'd0, d} * {13'd0, f}) + 23'd512;
        if (p[14])
        begin
            mag = 17'd65536;
        end
        else
        begin
            mag = t0 + {4'd0, prod[22:10]};
        end
        sval = $signed({1'b0, mag});
        return a[15] ? -sval : sval;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sine16(angle);
            cos_reg <= sine16(angle + 16'd16384);
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

>>> src/sprite_quad_vertex_batcher_core.sv
// sprite quad vertex batcher top level: slot lookup, rotation and vertex output
// a draw transaction runs in these steps; in_stall holds off the next acceptance until the last:
//   acceptance, slot lookup and sine, four products, one vertex per cycle unless out_stall holds it (4)
// the first vertex is registered in ST_OUT after ST_LOOK and ST_MUL; begin scene stays in ST_IDLE
// the slot cell row is searched combinationally by per-cell compare during lookup
// reset: limit 10000, batch count 0, one slot used; slot ids undefined until written
module sprite_quad_vertex_batcher_core #(
    parameter int TEXTURE_SLOTS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [13:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] size_x,
    input  logic signed [31:0] size_y,
    input  logic [15:0]        angle,
    input  logic [31:0]        rgba,
    input  logic [15:0]        texture_id,
    input  logic [15:0]        tiling,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] vert_x,
    output logic signed [31:0] vert_y,
    output logic signed [31:0] vert_z,
    output logic [31:0]        vert_rgba,
    output logic               tex_u,
    output logic               tex_v,
    output logic [4:0]         tex_slot,
    output logic [15:0]        vert_tiling,
    output logic               flush_before,
    output logic               last_vertex
);
    import sqvb_pkg::*;

    localparam int SuW = $clog2(TEXTURE_SLOTS + 1);
    localparam int SlW = $clog2(TEXTURE_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [13:0]        limit_reg;
    logic [13:0]        quads_reg;
    logic [SuW-1:0]     slots_reg;
    logic [1:0]         corner_reg;
    logic               out_valid_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg, sx_reg, sy_reg;
    logic [15:0]        angle_reg;
    logic [31:0]        rgba_reg;
    tex_id_t            tex_reg;
    logic [15:0]        tiling_reg;
    logic [SlW-1:0]     slot_reg;
    logic               flush_reg;
    logic signed [49:0] pa_reg, pb_reg, pc_reg, pd_reg;

    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic [31:0]        vrgba_reg;
    logic               vu_reg, vv_reg, vflush_reg, vlast_reg;
    logic [4:0]         vslot_reg;
    logic [15:0]        vtiling_reg;

    logic                     accept;
    logic                     load_out;
    logic                     quota_hit;
    logic [SuW-1:0]           su_eff;
    logic [TEXTURE_SLOTS-1:0] match;
    logic                     hit;
    logic [SlW-1:0]           hit_idx;
    logic                     do_append;
    logic                     table_full;
    logic [SlW-1:0]           new_slot;
    logic                     new_flush;
    logic [SuW-1:0]           new_slots;
    logic signed [17:0]       sin_q, cos_q;
    logic signed [50:0]       acc_x, acc_y;
    logic signed [50:0]       sh_x, sh_y;
    logic                     ex_pos, ey_pos;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    sqvb_sine u_sine (
        .clk   (clk),
        .en    (state_reg == ST_LOOK),
        .angle (angle_reg),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    assign quota_hit = (quads_reg >= limit_reg);
    assign su_eff    = quota_hit ? SuW'(1) : slots_reg;

    assign match[0] = 1'b0;
    genvar k;
    generate
        for (k = 1; k < TEXTURE_SLOTS; k++)
        begin : g_cell
            sqvb_slot_cell #(
                .CellIdx (k),
                .SuW     (SuW)
            ) u_cell (
                .clk   (clk),
                .query (tex_reg),
                .slots (su_eff),
                .wr_en (do_append && (new_slot == SlW'(k))),
                .match (match[k])
            );
        end
    endgenerate

    always_comb
    begin
        hit_idx = '0;
        for (int j = 1; j < TEXTURE_SLOTS; j++)
        begin
            hit_idx = hit_idx | (match[j] ? SlW'(j) : SlW'(0));
        end
    end

    assign hit        = |match;
    assign table_full = (su_eff >= SuW'(TEXTURE_SLOTS));
    assign do_append  = (state_reg == ST_LOOK) && (tex_reg != 16'd0) && !hit;

    always_comb
    begin
        new_flush = quota_hit;
        new_slots = su_eff;
        new_slot  = '0;
        if (tex_reg != 16'd0)
        begin
            if (hit)
            begin
                new_slot = hit_idx;
            end
            else if (table_full)
            begin
                new_flush = 1'b1;
                new_slot  = SlW'(1);
                new_slots = SuW'(2);
            end
            else
            begin
                new_slot  = SlW'(su_eff);
                new_slots = su_eff + SuW'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_DRAW)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (load_out && corner_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign ex_pos = (corner_reg == 2'd1) || (corner_reg == 2'd2);
    assign ey_pos = corner_reg[1];

    always_comb
    begin
        acc_x = (ex_pos ? 51'(pa_reg) : -51'(pa_reg))
              + (ey_pos ? -51'(pb_reg) : 51'(pb_reg)) + 51'sd65536;
        acc_y = (ex_pos ? 51'(pc_reg) : -51'(pc_reg))
              + (ey_pos ? 51'(pd_reg) : -51'(pd_reg)) + 51'sd65536;
        sh_x  = acc_x >>> 17;
        sh_y  = acc_y >>> 17;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            quads_reg     <= '0;
            slots_reg     <= SuW'(1);
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (accept && op == OP_BEGIN)
            begin
                quads_reg <= '0;
                slots_reg <= SuW'(1);
            end
            if (state_reg == ST_LOOK)
            begin
                quads_reg <= (new_flush && !quota_hit) ? 14'd1
                           : ((quota_hit ? 14'd0 : quads_reg) + 14'd1);
                slots_reg <= new_slots;
            end
            if (state_reg == ST_MUL)
            begin
                corner_reg <= '0;
            end
            else if (load_out)
            begin
                corner_reg <= corner_reg + 2'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            pz_reg     <= pos_z;
            sx_reg     <= size_x;
            sy_reg     <= size_y;
            angle_reg  <= angle;
            rgba_reg   <= rgba;
            tex_reg    <= texture_id;
            tiling_reg <= tiling;
        end
        if (state_reg == ST_LOOK)
        begin
            slot_reg  <= new_slot;
            flush_reg <= new_flush;
        end
        if (state_reg == ST_MUL)
        begin
            pa_reg <= 50'(cos_q) * 50'(sx_reg);
            pb_reg <= 50'(sin_q) * 50'(sy_reg);
            pc_reg <= 50'(sin_q) * 50'(sx_reg);
            pd_reg <= 50'(cos_q) * 50'(sy_reg);
        end
        if (load_out)
        begin
            vx_reg      <= px_reg + sh_x[31:0];
            vy_reg      <= py_reg + sh_y[31:0];
            vz_reg      <= pz_reg;
            vrgba_reg   <= (tex_reg == 16'd0) ? rgba_reg : WHITE;
            vu_reg      <= ex_pos;
            vv_reg      <= ey_pos;
            vslot_reg   <= 5'(slot_reg);
            vtiling_reg <= (tex_reg == 16'd0) ? TILING_ONE : tiling_reg;
            vflush_reg  <= flush_reg;
            vlast_reg   <= (corner_reg == 2'd3);
        end
    end

    assign out_valid    = out_valid_reg;
    assign vert_x       = vx_reg;
    assign vert_y       = vy_reg;
    assign vert_z       = vz_reg;
    assign vert_rgba    = vrgba_reg;
    assign tex_u        = vu_reg;
    assign tex_v        = vv_reg;
    assign tex_slot     = vslot_reg;
    assign vert_tiling  = vtiling_reg;
    assign flush_before = vflush_reg;
    assign last_vertex  = vlast_reg;

    a_slots_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        slots_reg != '0)
        else $error("slot count dropped to zero");

    a_draw_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_DRAW |=> state_reg == ST_LOOK)
        else $error("accepted draw did not start lookup");

    a_quota_restart: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK && quota_hit |=> quads_reg == 14'd1)
        else $error("quota flush did not restart batch count");

    a_untextured_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && tex_reg == 16'd0 |-> slot_reg == '0)
        else $error("untextured quad got a nonzero slot");

endmodule
